>>> hw/rtl/gtq_pkg.sv
// Shared types and constants for the grouped team queue.
// No dependencies; every other file imports this package.
package gtq_pkg;

   localparam int ID_W        = 10;
   localparam int TEAM_W      = 10;
   localparam int NODE_W      = 10;
   localparam int CNT_W       = NODE_W + 1;
   localparam int POOL_DEPTH  = 1 << NODE_W;
   localparam int ID_SPACE    = 1 << ID_W;
   localparam int MODE_W      = 2;
   localparam int STAT_W      = 2;

   // item modes
   localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // controller states
   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_ASSIGN = 10'b0000000100,
      ST_ELOOK  = 10'b0000001000,
      ST_ETEAM  = 10'b0000010000,
      ST_EDO    = 10'b0000100000,
      ST_DLOOK  = 10'b0001000000,
      ST_DTEAM  = 10'b0010000000,
      ST_DNODE  = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_ASSIGN,
      OP_ELOOK,
      OP_ETEAM,
      OP_EDO,
      OP_DLOOK,
      OP_DTEAM,
      OP_DNODE,
      OP_DDO,
      OP_DEMPTY,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   clear_addr;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              order_empty;
      logic              rsp_busy;
   } stat_type;

endpackage

>>> hw/rtl/gtq_req_if.sv
// Request channel of the grouped team queue: valid/ready plus the item fields.
// Depends on gtq_pkg.
interface gtq_req_if;
   import gtq_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ID_W-1:0]   element_id;
   logic [TEAM_W-1:0] team_id;
   modport source (output valid, mode, element_id, team_id, input ready);
   modport sink   (input valid, mode, element_id, team_id, output ready);
endinterface

>>> hw/rtl/gtq_rsp_if.sv
// Response channel of the grouped team queue: valid/ready plus the result fields.
// Depends on gtq_pkg.
interface gtq_rsp_if;
   import gtq_pkg::*;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   out_element;
   logic [STAT_W-1:0] status;
   modport source (output valid, out_element, status, input ready);
   modport sink   (input valid, out_element, status, output ready);
endinterface

>>> hw/rtl/gtq_ctrl.sv
// Controller of the grouped team queue: sequences the datapath per item.
// Depends on gtq_pkg.
module gtq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   output logic              req_ready,
   input  gtq_pkg::stat_type stat,
   output gtq_pkg::cmd_type  cmd
);
   import gtq_pkg::*;

   state_type       state_ff, state_in;
   logic [ID_W-1:0] clr_ff, clr_in;
   logic            done_ff, done_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and datapath command
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      done_in        = done_ff;
      cmd.op         = OP_NONE;
      cmd.clear_addr = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd.op = OP_CAPTURE;
               case (stat.mode)
                  MODE_ASSIGN:  state_in = ST_ASSIGN;
                  MODE_ENQUEUE: state_in = ST_ELOOK;
                  MODE_DEQUEUE: state_in = ST_DLOOK;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_ASSIGN: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_ASSIGN;
               state_in = ST_IDLE;
            end
         end
         ST_ELOOK: begin
            cmd.op   = OP_ELOOK;
            state_in = ST_ETEAM;
         end
         ST_ETEAM: begin
            cmd.op   = OP_ETEAM;
            state_in = ST_EDO;
         end
         ST_EDO: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_EDO;
               state_in = ST_IDLE;
            end
         end
         ST_DLOOK: begin
            if (stat.order_empty) begin
               if (!stat.rsp_busy) begin
                  cmd.op   = OP_DEMPTY;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.op   = OP_DLOOK;
               state_in = ST_DTEAM;
            end
         end
         ST_DTEAM: begin
            cmd.op   = OP_DTEAM;
            state_in = ST_DNODE;
         end
         ST_DNODE: begin
            if (!done_ff) begin
               cmd.op  = OP_DNODE;
               done_in = 1'b1;
            end else if (!stat.rsp_busy) begin
               cmd.op   = OP_DDO;
               done_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_NOP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // hold state; clear the tables after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         done_ff  <= done_in;
      end
   end

endmodule

>>> hw/rtl/gtq_dpath.sv
// Datapath of the grouped team queue: tables, node pool, order queue, result register.
// Depends on gtq_pkg.
module gtq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  gtq_pkg::cmd_type          cmd,
   output gtq_pkg::stat_type         stat,
   input  logic [gtq_pkg::MODE_W-1:0] req_mode,
   input  logic [gtq_pkg::ID_W-1:0]   req_element_id,
   input  logic [gtq_pkg::TEAM_W-1:0] req_team_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [gtq_pkg::ID_W-1:0]   rsp_out_element,
   output logic [gtq_pkg::STAT_W-1:0] rsp_status
);
   import gtq_pkg::*;

   // memories
   logic [TEAM_W-1:0] team_of_mem  [ID_SPACE];
   logic              waiting_mem  [1 << TEAM_W];
   logic [NODE_W-1:0] head_mem     [1 << TEAM_W];
   logic [NODE_W-1:0] tail_mem     [1 << TEAM_W];
   logic [ID_W:0]     order_mem    [POOL_DEPTH];
   logic [ID_W-1:0]   value_mem    [POOL_DEPTH];
   logic [NODE_W-1:0] link_mem     [POOL_DEPTH];

   // registered read data
   logic [TEAM_W-1:0] team_q;
   logic              waiting_q;
   logic [NODE_W-1:0] head_q, tail_q;
   logic [ID_W:0]     order_q;
   logic [ID_W-1:0]   value_q;
   logic [NODE_W-1:0] link_q;

   // item and control registers
   logic [ID_W-1:0]   elem_ff;
   logic [TEAM_W-1:0] tin_ff;
   logic [TEAM_W-1:0] team_ff, team_in;
   logic [NODE_W-1:0] ohead_ff, ohead_in, otail_ff, otail_in;
   logic [CNT_W-1:0]  ocount_ff, ocount_in;
   logic [NODE_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in, inuse_ff, inuse_in;
   logic              rvalid_ff, rvalid_in;
   logic [ID_W-1:0]   relem_ff, relem_in;
   logic [STAT_W-1:0] rstat_ff, rstat_in;

   // memory ports
   logic              team_we,  wait_we, head_we, tail_we, order_we, value_we, link_we;
   logic [ID_W-1:0]   team_wa;
   logic [TEAM_W-1:0] team_wd, wait_wa, head_wa, tail_wa, wait_ra, ht_ra;
   logic              wait_wd;
   logic [NODE_W-1:0] head_wd, tail_wd, order_wa, value_wa, link_wa, link_wd, node_ra;
   logic [ID_W:0]     order_wd;
   logic [ID_W-1:0]   value_wd;

   logic              node_ok, order_ok, is_solo;
   logic [NODE_W-1:0] new_node, deq_node;
   logic [TEAM_W-1:0] deq_team;

   assign node_ok  = (inuse_ff < CNT_W'(POOL_DEPTH));
   assign order_ok = (ocount_ff < CNT_W'(POOL_DEPTH));
   assign new_node = fresh_ff[CNT_W-1] ? free_ff : fresh_ff[NODE_W-1:0];
   assign is_solo  = order_q[ID_W];
   assign deq_team = order_q[TEAM_W-1:0];
   assign deq_node = head_q;

   assign stat.mode        = req_mode;
   assign stat.order_empty = (ocount_ff == '0);
   assign stat.rsp_busy    = rvalid_ff && !rsp_ready;

   assign rsp_valid       = rvalid_ff;
   assign rsp_out_element = relem_ff;
   assign rsp_status      = rstat_ff;

   // decode the operation into memory accesses and register updates
   always_comb begin
      team_we  = 1'b0; team_wa  = elem_ff;  team_wd  = tin_ff;
      wait_we  = 1'b0; wait_wa  = team_ff;  wait_wd  = 1'b0;
      head_we  = 1'b0; head_wa  = team_ff;  head_wd  = new_node;
      tail_we  = 1'b0; tail_wa  = team_ff;  tail_wd  = new_node;
      order_we = 1'b0; order_wa = otail_ff; order_wd = {1'b1, elem_ff};
      value_we = 1'b0; value_wa = new_node; value_wd = elem_ff;
      link_we  = 1'b0; link_wa  = tail_q;   link_wd  = new_node;
      wait_ra  = team_q;
      ht_ra    = team_q;
      node_ra  = free_ff;
      team_in  = team_ff;
      ohead_in = ohead_ff; otail_in = otail_ff; ocount_in = ocount_ff;
      free_in  = free_ff;  fresh_in = fresh_ff; inuse_in = inuse_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      relem_in  = relem_ff;
      rstat_in  = rstat_ff;
      case (cmd.op)
         OP_CLEAR: begin
            team_we = 1'b1; team_wa = cmd.clear_addr; team_wd = '0;
            wait_we = 1'b1; wait_wa = cmd.clear_addr; wait_wd = 1'b0;
         end
         OP_ASSIGN: begin
            team_we   = 1'b1;
            rvalid_in = 1'b1; relem_in = '0; rstat_in = STAT_OK;
         end
         OP_ETEAM: begin
            team_in = team_q;
         end
         OP_EDO: begin
            rvalid_in = 1'b1; relem_in = '0; rstat_in = STAT_OK;
            if (team_ff == '0) begin
               // unassigned element: solo entry
               if (!order_ok) begin
                  rstat_in = STAT_FULL;
               end else begin
                  order_we  = 1'b1;
                  otail_in  = otail_ff + 1'b1;
                  ocount_in = ocount_ff + 1'b1;
               end
            end else if (waiting_q) begin
               // join the waiting team behind its tail
               if (!node_ok) begin
                  rstat_in = STAT_FULL;
               end else begin
                  value_we = 1'b1;
                  link_we  = 1'b1;
                  tail_we  = 1'b1;
               end
            end else begin
               // new team entry
               if (!node_ok || !order_ok) begin
                  rstat_in = STAT_FULL;
               end else begin
                  value_we  = 1'b1;
                  head_we   = 1'b1;
                  tail_we   = 1'b1;
                  wait_we   = 1'b1; wait_wd = 1'b1;
                  order_we  = 1'b1; order_wd = {1'b0, team_ff};
                  otail_in  = otail_ff + 1'b1;
                  ocount_in = ocount_ff + 1'b1;
               end
            end
            // take the node
            if (rstat_in == STAT_OK && team_ff != '0) begin
               inuse_in = inuse_ff + 1'b1;
               if (fresh_ff[CNT_W-1]) free_in  = link_q;
               else                   fresh_in = fresh_ff + 1'b1;
            end
         end
         OP_DTEAM: begin
            ht_ra = deq_team;
         end
         OP_DNODE: begin
            node_ra = deq_node;
         end
         OP_DDO: begin
            rvalid_in = 1'b1; rstat_in = STAT_OK;
            if (is_solo) begin
               relem_in  = order_q[ID_W-1:0];
               ohead_in  = ohead_ff + 1'b1;
               ocount_in = ocount_ff - 1'b1;
            end else begin
               relem_in = value_q;
               if (deq_node == tail_q) begin
                  wait_we   = 1'b1; wait_wa = deq_team; wait_wd = 1'b0;
                  ohead_in  = ohead_ff + 1'b1;
                  ocount_in = ocount_ff - 1'b1;
               end else begin
                  head_we = 1'b1; head_wa = deq_team; head_wd = link_q;
               end
               // return the node to the free list
               link_we  = 1'b1; link_wa = deq_node; link_wd = free_ff;
               free_in  = deq_node;
               inuse_in = inuse_ff - 1'b1;
            end
         end
         OP_DEMPTY: begin
            rvalid_in = 1'b1; relem_in = '0; rstat_in = STAT_EMPTY;
         end
         OP_NOP: begin
            rvalid_in = 1'b1; relem_in = '0; rstat_in = STAT_OK;
         end
         default: ;
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (team_we) team_of_mem[team_wa] <= team_wd;
      team_q <= team_of_mem[elem_ff];
   end
   always_ff @(posedge clock) begin
      if (wait_we) waiting_mem[wait_wa] <= wait_wd;
      waiting_q <= waiting_mem[wait_ra];
   end
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (cmd.op == OP_DTEAM) head_q <= head_mem[ht_ra];
   end
   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      if (cmd.op == OP_ETEAM || cmd.op == OP_DTEAM) tail_q <= tail_mem[ht_ra];
   end
   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      if (cmd.op == OP_DLOOK) order_q <= order_mem[ohead_ff];
   end
   always_ff @(posedge clock) begin
      if (value_we) value_mem[value_wa] <= value_wd;
      if (cmd.op == OP_DNODE) value_q <= value_mem[node_ra];
   end
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      if (cmd.op == OP_ETEAM || cmd.op == OP_DNODE) link_q <= link_mem[node_ra];
   end

   // capture the item fields
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         elem_ff <= req_element_id;
         tin_ff  <= req_team_id;
      end
      team_ff  <= team_in;
      relem_ff <= relem_in;
      rstat_ff <= rstat_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ohead_ff  <= '0;
         otail_ff  <= '0;
         ocount_ff <= '0;
         free_ff   <= '0;
         fresh_ff  <= '0;
         inuse_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         ohead_ff  <= ohead_in;
         otail_ff  <= otail_in;
         ocount_ff <= ocount_in;
         free_ff   <= free_in;
         fresh_ff  <= fresh_in;
         inuse_ff  <= inuse_in;
         rvalid_ff <= rvalid_in;
      end
   end

endmodule

>>> hw/rtl/grouped_team_queue.sv
// Grouped team queue (team FIFO) with a shared linked-list node pool of 1024 nodes.
// After reset the block clears its team-assignment and team-waiting tables and
// accepts no item meanwhile. Each item then gives one result, its steps set by
// the chain of registered memory reads: team lookup or order-queue read, team
// head or tail, then the node pool; an empty dequeue skips them. One item is in
// work at a time; a waiting result holds the next item in its final step until
// it is taken.
// Depends on gtq_pkg, gtq_req_if, gtq_rsp_if, gtq_ctrl and gtq_dpath.
module grouped_team_queue (
   input  logic      clock,
   input  logic      reset,
   gtq_req_if.sink   req_chan,
   gtq_rsp_if.source rsp_chan
);
   import gtq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   gtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gtq_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_chan.mode),
      .req_element_id  (req_chan.element_id),
      .req_team_id     (req_chan.team_id),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_element (rsp_chan.out_element),
      .rsp_status      (rsp_chan.status)
   );

endmodule
